@@ src/cpg_pkg.sv @@
// cpg_pkg: beat types, fixed-point constants and the quarter-wave sine entry
// builder for the circle point generator. No dependencies.
package cpg_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int SINE_FRAC  = 30;
	localparam int SINE_W     = SINE_FRAC + 2;
	localparam int PROD_W     = SAMPLE_W + SINE_W;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30     = 64'd1 << SINE_FRAC;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] phase;
		logic signed [SAMPLE_W-1:0] center_x;
		logic signed [SAMPLE_W-1:0] center_y;
		logic signed [SAMPLE_W-1:0] radius;
	} sample_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_x;
		logic signed [SAMPLE_W-1:0] out_y;
	} point_t;

	function automatic longint unsigned mul_q30(input longint unsigned a,
		input longint unsigned b);
		return (a * b + (64'd1 << (SINE_FRAC - 1))) >> SINE_FRAC;
	endfunction

	// restoring division, only evaluated while the table is built
	function automatic longint unsigned udiv64(input longint unsigned n,
		input longint unsigned d);
		longint unsigned q;
		longint unsigned rem;
		int i;
		q = '0;
		rem = '0;
		for (i = 63; i >= 0; i--) begin
			rem = {rem[62:0], n[i]};
			if (rem >= d) begin
				rem = rem - d;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// sin(pi/2 * j / 2^addr_bits) in Q1.30, Taylor series to x^17
	function automatic logic [SINE_FRAC:0] sine_entry(input int unsigned j,
		input int unsigned addr_bits);
		longint unsigned jj;
		longint unsigned x;
		longint unsigned term;
		longint unsigned div;
		longint sum;
		int unsigned k;
		jj = 64'(j);
		x = (jj * HALF_PI_Q30 + (64'd1 << (addr_bits - 1))) >> addr_bits;
		term = x;
		sum = longint'(x);
		for (k = 1; k <= 8; k++) begin
			div = 64'((2 * k) * (2 * k + 1));
			term = udiv64(mul_q30(mul_q30(term, x), x), div);
			if (k[0]) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > longint'(ONE_Q30)) begin
			sum = longint'(ONE_Q30);
		end
		return sum[SINE_FRAC:0];
	endfunction

endpackage

@@ src/circle_point_generator.sv @@
// circle_point_generator: top level, four-stage point pipeline with sine table.
// Depends on cpg_pkg.
//
// Takes one sample beat per clock while sample_stall is low and returns one point
// beat per sample. Stage one registers the sample, stage two holds the sine and
// cosine read from a constant quarter-wave table of 2^TABLE_ADDR_BITS+1 entries
// built at elaboration, stage three holds the two radius products (24 x 32
// bits), and the output register holds the rounded, offset and saturated point.
// Each stage moves on when the one after it is empty or moving, so bubbles close
// up under output stall. The phase fraction has FRAC_BITS bits. With bypass set
// the point is the phase on x and zero on y. cfg_ready is always high.
module circle_point_generator #(
	parameter int TABLE_ADDR_BITS = 10,
	parameter int FRAC_BITS       = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  cpg_pkg::sample_t sample,
	output logic             point_valid,
	input  logic             point_stall,
	output cpg_pkg::point_t  point,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_data
);

	localparam int SW     = cpg_pkg::SAMPLE_W;
	localparam int QW     = cpg_pkg::SINE_W;
	localparam int PW     = cpg_pkg::PROD_W;
	localparam int U_BITS = TABLE_ADDR_BITS + 2;
	localparam int IDX_W  = TABLE_ADDR_BITS + 1;
	localparam int QLEN   = 1 << TABLE_ADDR_BITS;
	localparam int SUM_W  = SW + 3;

	localparam logic signed [PW-1:0] ROUND =
		PW'(1) <<< (cpg_pkg::SINE_FRAC - 1);
	localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((1 << (SW - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(1 << (SW - 1));

	typedef logic [cpg_pkg::SINE_FRAC:0] sine_tbl_t [QLEN+1];

	function automatic sine_tbl_t build_tbl();
		sine_tbl_t t;
		int unsigned j;
		for (j = 0; j <= QLEN; j++) begin
			t[j] = cpg_pkg::sine_entry(j, TABLE_ADDR_BITS);
		end
		return t;
	endfunction

	localparam sine_tbl_t SINE_TBL = build_tbl();

	function automatic logic signed [QW-1:0] quad_sine(input logic [1:0] quad,
		input logic [TABLE_ADDR_BITS-1:0] j);
		logic [IDX_W-1:0] idx;
		logic signed [QW-1:0] mag;
		idx = quad[0] ? (IDX_W'(QLEN) - {1'b0, j}) : {1'b0, j};
		mag = QW'(SINE_TBL[idx]);
		return quad[1] ? -mag : mag;
	endfunction

	function automatic logic signed [SW-1:0] round_add(
		input logic signed [PW-1:0] p, input logic signed [SW-1:0] c);
		logic signed [PW-1:0] r;
		logic signed [SUM_W-1:0] v;
		r = (p + ROUND) >>> cpg_pkg::SINE_FRAC;
		v = SUM_W'(r) + SUM_W'(c);
		if (v > SAT_MAX) begin
			v = SAT_MAX;
		end else if (v < SAT_MIN) begin
			v = SAT_MIN;
		end
		return v[SW-1:0];
	endfunction

	logic bypass_q;

	logic v_s1, v_s2, v_s3, point_valid_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_out;

	cpg_pkg::sample_t smp_s1;
	logic signed [SW-1:0] phase_s2, cx_s2, cy_s2, radius_s2;
	logic signed [QW-1:0] sin_s2, cos_s2;
	logic signed [SW-1:0] phase_s3, cx_s3, cy_s3;
	logic signed [PW-1:0] prod_x_s3, prod_y_s3;
	cpg_pkg::point_t point_q;

	logic [FRAC_BITS-1:0] frac;
	logic [U_BITS-1:0] turn;
	logic [1:0] quad;

	assign frac = smp_s1.phase[FRAC_BITS-1:0];

	generate
		if (FRAC_BITS >= U_BITS) begin : g_trunc
			assign turn = frac[FRAC_BITS-1 -: U_BITS];
		end else begin : g_pad
			assign turn = {frac, {(U_BITS - FRAC_BITS){1'b0}}};
		end
	endgenerate

	assign quad = turn[U_BITS-1 -: 2];

	assign rdy_out      = !point_valid_q || !point_stall;
	assign rdy_s3       = !v_s3 || rdy_out;
	assign rdy_s2       = !v_s2 || rdy_s3;
	assign rdy_s1       = !v_s1 || rdy_s2;
	assign sample_stall = !rdy_s1;
	assign point_valid  = point_valid_q;
	assign point        = point_q;
	assign cfg_ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q      <= 1'b0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			point_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				bypass_q <= cfg_data;
			end
			if (rdy_s1) begin
				v_s1 <= sample_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_out) begin
				point_valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && rdy_s1) begin
			smp_s1 <= sample;
		end
		if (v_s1 && rdy_s2) begin
			phase_s2  <= smp_s1.phase;
			cx_s2     <= smp_s1.center_x;
			cy_s2     <= smp_s1.center_y;
			radius_s2 <= smp_s1.radius;
			sin_s2    <= quad_sine(quad, turn[TABLE_ADDR_BITS-1:0]);
			cos_s2    <= quad_sine(quad + 2'd1, turn[TABLE_ADDR_BITS-1:0]);
		end
		if (v_s2 && rdy_s3) begin
			phase_s3  <= phase_s2;
			cx_s3     <= cx_s2;
			cy_s3     <= cy_s2;
			prod_x_s3 <= PW'(radius_s2) * PW'(cos_s2);
			prod_y_s3 <= PW'(radius_s2) * PW'(sin_s2);
		end
		if (v_s3 && rdy_out) begin
			if (bypass_q) begin
				point_q.out_x <= phase_s3;
				point_q.out_y <= '0;
			end else begin
				point_q.out_x <= round_add(prod_x_s3, cx_s3);
				point_q.out_y <= round_add(prod_y_s3, cy_s3);
			end
		end
	end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: self-checking bench for circle_point_generator; a scoreboard class predicts each
// point from its own quarter-wave sine table. Depends on cpg_pkg and the block's RTL.

class point_scoreboard;
	localparam int ADDR_BITS = 10;
	localparam int FRAC = 16;
	localparam int TURN_W = ADDR_BITS + 2;
	localparam int QUARTER = 1 << ADDR_BITS;
	localparam longint unsigned HALF_PI = 64'd1686629713;
	localparam longint unsigned ROUND30 = 64'd1 << 29;
	localparam longint SAMPLE_MAX = 64'sd8388607;
	localparam longint SAMPLE_MIN = -64'sd8388608;

	longint sine_lut[QUARTER + 1];
	logic bypass;
	cpg_pkg::point_t pending_points[$];
	int noted;
	int checked;
	int errors;

	function new();
		longint unsigned x;
		longint unsigned term;
		longint unsigned p;
		longint sum;
		bypass = 1'b0;
		noted = 0;
		checked = 0;
		errors = 0;
		for (int j = 0; j <= QUARTER; j++) begin
			x = (64'(j) * HALF_PI + (64'd1 << (ADDR_BITS - 1))) >> ADDR_BITS;
			term = x;
			sum = longint'(x);
			for (int k = 1; k <= 8; k++) begin
				p = (term * x + ROUND30) >> 30;
				term = ((p * x + ROUND30) >> 30) / 64'((2 * k) * (2 * k + 1));
				if (k % 2 == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			if (sum > (64'sd1 << 30)) begin
				sum = 64'sd1 << 30;
			end
			sine_lut[j] = sum;
		end
	endfunction

	function longint turn_sine(logic [TURN_W-1:0] t);
		int idx;
		longint v;
		idx = t[ADDR_BITS] ? QUARTER - int'(t[ADDR_BITS-1:0]) : int'(t[ADDR_BITS-1:0]);
		v = sine_lut[idx];
		return t[TURN_W-1] ? -v : v;
	endfunction

	function logic [23:0] scale_offset(logic signed [23:0] r, longint s,
		logic signed [23:0] c);
		longint v;
		v = ((longint'(r) * s + 64'sd536870912) >>> 30) + longint'(c);
		if (v > SAMPLE_MAX) begin
			v = SAMPLE_MAX;
		end
		if (v < SAMPLE_MIN) begin
			v = SAMPLE_MIN;
		end
		return v[23:0];
	endfunction

	function cpg_pkg::point_t circle_point(cpg_pkg::sample_t s);
		cpg_pkg::point_t p;
		logic [TURN_W-1:0] turn;
		logic [TURN_W-1:0] turn_cos;
		if (bypass) begin
			p.out_x = s.phase;
			p.out_y = '0;
			return p;
		end
		turn = s.phase[FRAC-1 -: TURN_W];
		turn_cos = turn + TURN_W'(QUARTER);
		p.out_x = scale_offset(s.radius, turn_sine(turn_cos), s.center_x);
		p.out_y = scale_offset(s.radius, turn_sine(turn), s.center_y);
		return p;
	endfunction

	function int pending();
		return pending_points.size();
	endfunction

	function void note_sample(cpg_pkg::sample_t s);
		pending_points.push_back(circle_point(s));
		noted++;
	endfunction

	task report_mismatch(string what);
		errors++;
		if (errors <= 25) begin
			$display("mismatch at %0t: %s", $time, what);
		end
	endtask

	task check_point(cpg_pkg::point_t got);
		cpg_pkg::point_t want;
		if (pending_points.size() == 0) begin
			report_mismatch("point beat with no sample outstanding");
		end else begin
			want = pending_points.pop_front();
			checked++;
			if (got.out_x !== want.out_x) begin
				report_mismatch($sformatf("out_x got %h want %h", got.out_x, want.out_x));
			end
			if (got.out_y !== want.out_y) begin
				report_mismatch($sformatf("out_y got %h want %h", got.out_y, want.out_y));
			end
		end
	endtask
endclass

module tb_top;

	localparam int QUIET_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	cpg_pkg::sample_t sample = '0;
	logic point_valid;
	logic point_stall = 1'b0;
	cpg_pkg::point_t point;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;

	int idle_pct = 20;
	int quiet = 0;
	point_scoreboard sb;

	circle_point_generator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point(point),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		point_stall <= ($urandom_range(99) < idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && point_valid && !point_stall) begin
			sb.check_point(point);
		end
	end

	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (point_valid && !point_stall) ||
			(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
		end
		$display("timeout: no beat for %0d cycles", QUIET_LIMIT);
		$display("FAILURE");
		$finish;
	end

	function automatic cpg_pkg::sample_t mk(logic [23:0] ph, logic [23:0] cx,
		logic [23:0] cy, logic [23:0] r);
		cpg_pkg::sample_t s;
		s.phase = ph;
		s.center_x = cx;
		s.center_y = cy;
		s.radius = r;
		return s;
	endfunction

	function automatic cpg_pkg::sample_t rand_sample();
		cpg_pkg::sample_t s;
		logic [17:0] r18;
		logic [19:0] cx20;
		logic [19:0] cy20;
		s = mk(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
		r18 = 18'($urandom);
		cx20 = 20'($urandom);
		cy20 = 20'($urandom);
		case ($urandom_range(3))
			0: begin
			end
			1: begin
				s.radius = {{6{r18[17]}}, r18};
				s.center_x = {{4{cx20[19]}}, cx20};
				s.center_y = {{4{cy20[19]}}, cy20};
			end
			2: begin
				s.center_x = '0;
				s.center_y = '0;
			end
			default: begin
				s.phase[13:0] = '0;
				s.radius = {{6{r18[17]}}, r18};
			end
		endcase
		return s;
	endfunction

	task automatic send_sample(input cpg_pkg::sample_t s);
		sample <= s;
		sample_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (sample_stall);
		sb.note_sample(s);
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (6) @(posedge clk);
	endtask

	task automatic write_bypass(input logic v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.bypass = v;
	endtask

	task automatic send_random(input int count);
		repeat (count) begin
			if ($urandom_range(99) < idle_pct) begin
				sample_valid <= 1'b0;
				@(posedge clk);
				while ($urandom_range(99) < idle_pct) begin
					@(posedge clk);
				end
			end
			send_sample(rand_sample());
		end
	endtask

	initial begin
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_bypass(1'b0);

		// quadrant edges, truncation, extremes, saturation, mirrored radius
		send_sample(mk(24'h000000, 24'h000000, 24'h000000, 24'h010000));
		send_sample(mk(24'h004000, 24'h000000, 24'h000000, 24'h010000));
		send_sample(mk(24'h008000, 24'h000000, 24'h000000, 24'h010000));
		send_sample(mk(24'h00C000, 24'h000000, 24'h000000, 24'h010000));
		send_sample(mk(24'h00FFFF, 24'h000000, 24'h000000, 24'h010000));
		send_sample(mk(24'h000008, 24'h000000, 24'h000000, 24'h7FFFFF));
		send_sample(mk(24'h7F4000, 24'h000000, 24'h000000, 24'h7FFFFF));
		send_sample(mk(24'h800000, 24'h000000, 24'h000000, 24'h800000));
		send_sample(mk(24'h000000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
		send_sample(mk(24'h008000, 24'h800000, 24'h800000, 24'h7FFFFF));
		send_sample(mk(24'hFF2000, 24'h020000, 24'hFE0000, 24'hFF0000));
		send_sample(mk(24'h123456, 24'h7FFFFF, 24'h800000, 24'h000000));
		send_sample(mk(24'h002000, 24'h000000, 24'h000000, 24'h400000));
		send_sample(mk(24'hFFFFFF, 24'h000001, 24'hFFFFFF, 24'h000001));
		drain();

		write_bypass(1'b1);
		send_sample(mk(24'h7FFFFF, 24'h123456, 24'h654321, 24'h7FFFFF));
		send_sample(mk(24'h800000, 24'h7FFFFF, 24'h800000, 24'h800000));
		send_sample(mk(24'h00C000, 24'hFFFFFF, 24'h000000, 24'h010000));
		send_sample(mk(24'h000000, 24'h800000, 24'h7FFFFF, 24'hFFFFFF));
		send_random(150);
		drain();

		write_bypass(1'b0);
		send_random(300);
		idle_pct = 0;
		send_random(200);
		idle_pct = 20;
		drain();
		send_random(230);
		drain();

		write_bypass(1'b1);
		send_random(20);
		drain();
		repeat (10) @(posedge clk);

		$display("%0d samples sent, %0d points checked", sb.noted, sb.checked);
		$display("bypass off and on, quadrant edges, saturation, stalls on both sides");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
